// ===== rtl/lru_mru_page_replacement_defines.svh =====
// Assertion macros used by the page replacement top level.
`ifndef LRU_MRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_MRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmpr assertion failed");

// Next-cycle implication, checked outside reset.
`define LMPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmpr assertion failed");

`endif

// ===== rtl/lmpr_pkg.sv =====
// Package with constants and types for the page replacement block.
`timescale 1ns / 1ps
`default_nettype none

package lmpr_pkg;

    localparam int STACK_DEPTH_DEF  = 8;
    localparam int PAGE_ID_BITS_DEF = 16;
    localparam int PAGE_ID_W        = 16;
    localparam int COUNT_W          = 32;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_MRU = 1'b1;

    // Control broadcast from the top level to every stack cell.
    typedef struct packed {
        logic accept;      // a reference is transferred this cycle
        logic hit;         // the reference matched a resident page
        logic miss_shift;  // on a miss, occupied cells shift toward the tail
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lru_mru_page_replacement.sv =====
// Top level of the LRU / MRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_mru_page_replacement_defines.svh"

// Usage:
// A page reference arrives on page_id with in_valid / in_ready; a transfer
// happens when both are high. Each reference gives exactly one result on the
// output channel (hit, evicted_valid, evicted_page, hit_count, fault_count)
// with out_valid / out_ready.
// The recency stack is a row of cells, head first. All cells compare the
// reference at once and shift toward the tail on the same edge: the result
// appears in the cycle after the input transfer, and one reference per cycle
// is sustained while the receiver keeps out_ready high.
// The result sits in an output register. While the receiver stalls,
// in_ready is low and the stack and counters hold their state.
// The policy register is written through cfg_we / cfg_wdata (0 = LRU,
// 1 = MRU) and takes effect from the next miss.
// Reset empties the stack, clears both counters, selects LRU and drops
// any pending result. Stack contents need no clearing since only occupied
// cells take part in a compare.
module lru_mru_page_replacement #(
    parameter int STACK_DEPTH  = lmpr_pkg::STACK_DEPTH_DEF,
    parameter int PAGE_ID_BITS = lmpr_pkg::PAGE_ID_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lmpr_pkg::PAGE_ID_W-1:0] page_id,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic                                evicted_valid,
    output logic [lmpr_pkg::PAGE_ID_W-1:0]      evicted_page,
    output logic [lmpr_pkg::COUNT_W-1:0]        hit_count,
    output logic [lmpr_pkg::COUNT_W-1:0]        fault_count
);
    import lmpr_pkg::*;

    localparam int OCC_W = $clog2(STACK_DEPTH + 1);

    logic                    policy_reg;
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic [COUNT_W-1:0]      hits_reg, hits_next;
    logic [COUNT_W-1:0]      faults_reg, faults_next;
    logic                    out_valid_reg;
    logic                    hit_reg;
    logic                    ev_valid_reg;
    logic [PAGE_ID_W-1:0]    ev_page_reg;

    logic                    accept;
    logic                    full;
    logic                    hit_w;
    logic                    evict_w;
    logic [PAGE_ID_BITS-1:0] id_w;
    logic [PAGE_ID_BITS-1:0] victim_w;
    logic [STACK_DEPTH-1:0]  occupied;
    logic [STACK_DEPTH:0]    seen;
    logic [PAGE_ID_BITS-1:0] cell_data [STACK_DEPTH];
    cell_ctrl_t              ctrl;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign id_w     = PAGE_ID_BITS'(page_id);
    assign full     = (occ_reg == OCC_W'(STACK_DEPTH));

    assign seen[0] = 1'b0;
    assign hit_w   = seen[STACK_DEPTH];
    assign evict_w = !hit_w && full;

    assign ctrl.accept     = accept;
    assign ctrl.hit        = hit_w;
    assign ctrl.miss_shift = !full || (policy_reg == POLICY_LRU);

    genvar k;
    generate
        for (k = 0; k < STACK_DEPTH; k++)
        begin : g_cell
            assign occupied[k] = (occ_reg > OCC_W'(k));
            if (k == 0)
            begin : g_head
                lmpr_cell #(
                    .PAGE_ID_BITS (PAGE_ID_BITS),
                    .HEAD         (1'b1)
                ) u_cell (
                    .clk           (clk),
                    .ctrl          (ctrl),
                    .ref_id        (id_w),
                    .occupied      (occupied[k]),
                    .prev_occupied (1'b1),
                    .prev_data     (id_w),
                    .seen_in       (seen[k]),
                    .seen_out      (seen[k+1]),
                    .data          (cell_data[k])
                );
            end
            else
            begin : g_body
                lmpr_cell #(
                    .PAGE_ID_BITS (PAGE_ID_BITS),
                    .HEAD         (1'b0)
                ) u_cell (
                    .clk           (clk),
                    .ctrl          (ctrl),
                    .ref_id        (id_w),
                    .occupied      (occupied[k]),
                    .prev_occupied (occupied[k-1]),
                    .prev_data     (cell_data[k-1]),
                    .seen_in       (seen[k]),
                    .seen_out      (seen[k+1]),
                    .data          (cell_data[k])
                );
            end
        end
    endgenerate

    // MRU drops the head page; LRU drops the tail page.
    assign victim_w = (policy_reg == POLICY_MRU) ? cell_data[0] : cell_data[STACK_DEPTH-1];

    always_comb
    begin
        occ_next    = occ_reg;
        hits_next   = hits_reg;
        faults_next = faults_reg;
        if (accept)
        begin
            if (hit_w)
            begin
                if (hits_reg != '1)
                begin
                    hits_next = hits_reg + COUNT_W'(1);
                end
            end
            else
            begin
                if (faults_reg != '1)
                begin
                    faults_next = faults_reg + COUNT_W'(1);
                end
                if (!full)
                begin
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_LRU;
            occ_reg       <= '0;
            hits_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            occ_reg    <= occ_next;
            hits_reg   <= hits_next;
            faults_reg <= faults_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= hit_w;
            ev_valid_reg <= evict_w;
            ev_page_reg  <= evict_w ? PAGE_ID_W'(victim_w) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    // Counters only move on an input transfer, which also reloads the output.
    assign hit_count     = hits_reg;
    assign fault_count   = faults_reg;

    `LMPR_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(STACK_DEPTH))
    `LMPR_ASSERT_NXT(a_fill_grows, clk, rst_n, accept && !hit_w && !full, occ_reg == $past(occ_reg) + OCC_W'(1))
    `LMPR_ASSERT_NXT(a_hit_counts, clk, rst_n, accept && hit_w && hits_reg != '1, hits_reg == $past(hits_reg) + COUNT_W'(1))
    `LMPR_ASSERT_IMP(a_evict_fault, clk, rst_n, out_valid_reg && ev_valid_reg, !hit_reg && faults_reg != '0)

endmodule

`default_nettype wire

// ===== rtl/lmpr_cell.sv =====
// One entry of the recency stack: holds a page id, compares it and shifts.
`timescale 1ns / 1ps
`default_nettype none

module lmpr_cell #(
    parameter int  PAGE_ID_BITS = 16,
    parameter bit  HEAD         = 1'b0
) (
    input  wire logic                     clk,
    input  wire lmpr_pkg::cell_ctrl_t     ctrl,
    input  wire logic [PAGE_ID_BITS-1:0]  ref_id,
    input  wire logic                     occupied,
    input  wire logic                     prev_occupied,
    input  wire logic [PAGE_ID_BITS-1:0]  prev_data,
    input  wire logic                     seen_in,
    output logic                          seen_out,
    output logic [PAGE_ID_BITS-1:0]       data
);
    import lmpr_pkg::*;

    logic [PAGE_ID_BITS-1:0] data_reg;
    logic                    match;
    logic                    load;

    assign match    = occupied && (data_reg == ref_id);
    assign seen_out = seen_in || match;

    // On a hit, every cell in front of the matching one shifts by one place.
    // On a miss, occupied cells shift unless an MRU eviction reuses the head.
    // The head always takes the new reference.
    assign load = ctrl.accept &&
                  (ctrl.hit ? !seen_in : ((ctrl.miss_shift && prev_occupied) || HEAD));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= prev_data;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire
